// ----- src/matrix3_inverse_fixed_defines.svh -----
// Assertion macros for the 3x3 fixed-point matrix inverse.
// Used by the port checker; no other dependencies.
`ifndef MATRIX3_INVERSE_FIXED_DEFINES_SVH
`define MATRIX3_INVERSE_FIXED_DEFINES_SVH

// Same-cycle implication, disabled while rst is low.
`define M3I_ASSERT_IMP(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rst)) (pre) |-> (post)) \
    else $error("m3i check failed");

// Next-cycle implication, disabled while rst is low.
`define M3I_ASSERT_NXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rst)) (pre) |=> (post)) \
    else $error("m3i check failed");

`endif

// ----- src/m3i_pkg.sv -----
// Package for the 3x3 fixed-point matrix inverse: request types,
// cofactor index tables and the fixed-point multiply. No dependencies.
`timescale 1ns / 1ps

package m3i_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned N_ENT         = 9;

  // Entry indices of the two products that form each adjugate cofactor.
  localparam int unsigned PA_IDX [N_ENT] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
  localparam int unsigned PB_IDX [N_ENT] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
  localparam int unsigned PC_IDX [N_ENT] = '{5, 2, 2, 5, 2, 2, 4, 1, 1};
  localparam int unsigned PD_IDX [N_ENT] = '{7, 7, 4, 6, 6, 3, 6, 6, 3};

  // Inverse entries whose adjugate sign is negative.
  localparam logic [N_ENT-1:0] NEG_MASK = 9'b010101010;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [N_ENT-1:0][WORD_W-1:0] ent_vec_t;

  typedef struct packed {
    logic [31:0] m_r1c1;
    logic [31:0] m_r1c2;
    logic [31:0] m_r1c3;
    logic [31:0] m_r2c1;
    logic [31:0] m_r2c2;
    logic [31:0] m_r2c3;
    logic [31:0] m_r3c1;
    logic [31:0] m_r3c2;
    logic [31:0] m_r3c3;
  } in_t;

  typedef struct packed {
    logic [31:0] inv_r1c1;
    logic [31:0] inv_r1c2;
    logic [31:0] inv_r1c3;
    logic [31:0] inv_r2c1;
    logic [31:0] inv_r2c2;
    logic [31:0] inv_r2c3;
    logic [31:0] inv_r3c1;
    logic [31:0] inv_r3c2;
    logic [31:0] inv_r3c3;
    logic        singular;
  } out_t;

  typedef struct packed {
    ent_vec_t cof;
    word_t    det;
  } det_item_t;

  typedef struct packed {
    ent_vec_t cof;
    logic     sign;
    logic     zero;
  } div_pay_t;

  typedef struct packed {
    ent_vec_t cof;
    word_t    rcp;
    logic     zero;
  } rcp_item_t;

  function automatic word_t fx_mul(input word_t a, input word_t b, input int unsigned frac);
    logic signed [2*WORD_W-1:0] p;
    p = signed'(a) * signed'(b);
    fx_mul = WORD_W'(p >>> frac);
  endfunction

endpackage

// ----- src/m3i_cofactor.sv -----
// Cofactor and determinant stages: four registered steps.
// Depends on m3i_pkg.
`timescale 1ns / 1ps

module m3i_cofactor #(
  parameter int unsigned FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  m3i_pkg::in_t      in_data,
  output logic              out_valid,
  output m3i_pkg::det_item_t out_item
);

  m3i_pkg::ent_vec_t a;
  m3i_pkg::ent_vec_t pa_r, pb_r, cof_r, cof2_r, cof3_r;
  logic [2:0][31:0]  row_r, row2_r;
  logic [2:0][31:0]  d_r;
  m3i_pkg::word_t    det_r;
  logic              v1_r, v2_r, v3_r, v4_r;

  always_comb begin
    a[0] = in_data.m_r1c1;
    a[1] = in_data.m_r1c2;
    a[2] = in_data.m_r1c3;
    a[3] = in_data.m_r2c1;
    a[4] = in_data.m_r2c2;
    a[5] = in_data.m_r2c3;
    a[6] = in_data.m_r3c1;
    a[7] = in_data.m_r3c2;
    a[8] = in_data.m_r3c3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < m3i_pkg::N_ENT; k++) begin
        pa_r[k]  <= m3i_pkg::fx_mul(a[m3i_pkg::PA_IDX[k]], a[m3i_pkg::PB_IDX[k]], FRAC_BITS);
        pb_r[k]  <= m3i_pkg::fx_mul(a[m3i_pkg::PC_IDX[k]], a[m3i_pkg::PD_IDX[k]], FRAC_BITS);
        cof_r[k] <= pa_r[k] - pb_r[k];
      end
      row_r  <= {a[2], a[1], a[0]};
      row2_r <= row_r;
      d_r[0] <= m3i_pkg::fx_mul(row2_r[0], cof_r[0], FRAC_BITS);
      d_r[1] <= m3i_pkg::fx_mul(row2_r[1], cof_r[3], FRAC_BITS);
      d_r[2] <= m3i_pkg::fx_mul(row2_r[2], cof_r[6], FRAC_BITS);
      cof2_r <= cof_r;
      det_r  <= d_r[0] - d_r[1] + d_r[2];
      cof3_r <= cof2_r;
    end
  end

  assign out_valid    = v4_r;
  assign out_item.cof = cof3_r;
  assign out_item.det = det_r;

endmodule

// ----- src/m3i_recip.sv -----
// Reciprocal of the determinant: restoring divider, one quotient bit
// per stage, cofactors carried alongside. Depends on m3i_pkg.
`timescale 1ns / 1ps

module m3i_recip #(
  parameter int unsigned FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  m3i_pkg::det_item_t in_item,
  output logic               out_valid,
  output m3i_pkg::rcp_item_t out_item
);

  localparam int unsigned QB = 2 * FRAC_BITS + 1;
  localparam logic [QB-1:0] NUM = {1'b1, {(QB-1){1'b0}}};

  logic [31:0]       rem_r [QB];
  logic [31:0]       mag_r [QB];
  logic [QB-1:0]     q_r   [QB];
  m3i_pkg::div_pay_t pay_r [QB];
  logic              v_r   [QB];

  logic [31:0]       mag0;
  m3i_pkg::div_pay_t pay0;

  always_comb begin
    mag0      = in_item.det[31] ? 32'(32'd0 - in_item.det) : in_item.det;
    pay0.cof  = in_item.cof;
    pay0.sign = in_item.det[31];
    pay0.zero = (in_item.det == '0);
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [31:0]       rem_in, mag_in;
    logic [QB-1:0]     q_in;
    logic              v_in;
    m3i_pkg::div_pay_t pay_in;
    logic [32:0]       trial;
    logic              ge;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign mag_in = mag0;
      assign q_in   = '0;
      assign v_in   = in_valid;
      assign pay_in = pay0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign mag_in = mag_r[s-1];
      assign q_in   = q_r[s-1];
      assign v_in   = v_r[s-1];
      assign pay_in = pay_r[s-1];
    end

    assign trial = {rem_in, NUM[QB-1-s]};
    assign ge    = (trial >= {1'b0, mag_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? 32'(trial - {1'b0, mag_in}) : trial[31:0];
        q_r[s]   <= {q_in[QB-2:0], ge};
        mag_r[s] <= mag_in;
        pay_r[s] <= pay_in;
      end
    end
  end

  assign out_valid     = v_r[QB-1];
  assign out_item.cof  = pay_r[QB-1].cof;
  assign out_item.zero = pay_r[QB-1].zero;
  assign out_item.rcp  = pay_r[QB-1].sign ? 32'(32'd0 - 32'(q_r[QB-1])) : 32'(q_r[QB-1]);

endmodule

// ----- src/m3i_scale.sv -----
// Scaling of the adjugate by the reciprocal, sign and singular handling,
// and the output register. Depends on m3i_pkg.
`timescale 1ns / 1ps

module m3i_scale #(
  parameter int unsigned FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  m3i_pkg::rcp_item_t in_item,
  output logic               out_valid,
  output m3i_pkg::out_t      out_data
);

  m3i_pkg::ent_vec_t prod_r, res_nxt, res_r;
  logic              zero_r, sing_r;
  logic              v1_r, v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_comb begin
    for (int k = 0; k < m3i_pkg::N_ENT; k++) begin
      if (zero_r) begin
        res_nxt[k] = '0;
      end else if (m3i_pkg::NEG_MASK[k]) begin
        res_nxt[k] = 32'd0 - prod_r[k];
      end else begin
        res_nxt[k] = prod_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < m3i_pkg::N_ENT; k++) begin
        prod_r[k] <= m3i_pkg::fx_mul(in_item.rcp, in_item.cof[k], FRAC_BITS);
      end
      zero_r <= in_item.zero;
      res_r  <= res_nxt;
      sing_r <= zero_r;
    end
  end

  assign out_valid = v2_r;
  assign out_data  = m3i_pkg::out_t'({res_r[0], res_r[1], res_r[2], res_r[3], res_r[4],
                                      res_r[5], res_r[6], res_r[7], res_r[8], sing_r});

endmodule

// ----- src/matrix3_inverse_fixed.sv -----
// 3x3 Q16.16 matrix inverse by adjugate; one request per cycle unless a result waits untaken.
// Pipeline: 4 cofactor/determinant stages, 2*FRAC_BITS+1 divider stages
// (one quotient bit each), 2 scale stages.
// The whole pipeline holds while a result waits untaken.
// Reset: synchronous active-low rst_n clears all valid bits.
`timescale 1ns / 1ps

module matrix3_inverse_fixed #(
  parameter int unsigned FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  m3i_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output m3i_pkg::out_t out_data
);

  logic               en;
  logic               det_valid, rcp_valid;
  m3i_pkg::det_item_t det_item;
  m3i_pkg::rcp_item_t rcp_item;

  assign en       = out_ready || !out_valid;
  assign in_ready = en;

  m3i_cofactor #(.FRAC_BITS(FRAC_BITS)) u_cof (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_valid), .in_data(in_data),
    .out_valid(det_valid), .out_item(det_item)
  );

  m3i_recip #(.FRAC_BITS(FRAC_BITS)) u_rcp (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(det_valid), .in_item(det_item),
    .out_valid(rcp_valid), .out_item(rcp_item)
  );

  m3i_scale #(.FRAC_BITS(FRAC_BITS)) u_scl (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(rcp_valid), .in_item(rcp_item),
    .out_valid(out_valid), .out_data(out_data)
  );

endmodule

// ----- src/m3i_checker.sv -----
// Port checker for matrix3_inverse_fixed, bound to the top level.
// Depends on m3i_pkg and matrix3_inverse_fixed_defines.svh.
`timescale 1ns / 1ps
`include "matrix3_inverse_fixed_defines.svh"

module m3i_port_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input m3i_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input m3i_pkg::out_t out_data
);

  `M3I_ASSERT_NXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid && $stable(in_data))
  `M3I_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `M3I_ASSERT_IMP(a_sing_zero, clk, rst_n, out_valid && out_data.singular, out_data[m3i_pkg::N_ENT*m3i_pkg::WORD_W:1] == '0)
  `M3I_ASSERT_IMP(a_ready_empty, clk, rst_n, !out_valid, in_ready)
  `M3I_ASSERT_IMP(a_reset_empty, clk, 1'b1, $past(!rst_n), !out_valid)

endmodule

bind matrix3_inverse_fixed m3i_port_checker u_chk (.*);
